### rtl/core/pbd_particle_chain_step_assert.svh
// ----------------------------------------------------------------------------
// pbd assertion macros
// Shared property shapes for the particle chain assertions; they use the
// clk and rst_n of the module that expands them.
// ----------------------------------------------------------------------------
`ifndef PBD_PARTICLE_CHAIN_STEP_ASSERT_SVH
`define PBD_PARTICLE_CHAIN_STEP_ASSERT_SVH

// same-cycle implication
`define PBD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbd assertion failed");

// next-cycle implication
`define PBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbd assertion failed");

`endif

### rtl/core/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Types, register map and saturation helper of the particle chain block.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int SLOT_W = 4;
    localparam int WIDE_W = 68;

    localparam int CNT_W  = 5;
    localparam int TS_W   = 17;
    localparam int GRAV_W = 18;
    localparam int DAMP_W = 17;
    localparam int REST_W = 21;
    localparam int PASS_W = 4;

    typedef logic signed [31:0] q_t;
    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_COUNT = 3'd0;
    localparam reg_idx_t REG_TSTEP = 3'd1;
    localparam reg_idx_t REG_GRAV  = 3'd2;
    localparam reg_idx_t REG_DAMP  = 3'd3;
    localparam reg_idx_t REG_REST  = 3'd4;
    localparam reg_idx_t REG_PASS  = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic signed [WIDE_W-1:0] Q_MAX = 68'sd2147483647;
    localparam logic signed [WIDE_W-1:0] Q_MIN = -68'sd2147483648;

    function automatic q_t sat32(input logic signed [WIDE_W-1:0] x);
        q_t r;
        if (x > Q_MAX) begin
            r = 32'sh7fffffff;
        end
        else if (x < Q_MIN) begin
            r = 32'sh80000000;
        end
        else begin
            r = q_t'(x[31:0]);
        end
        return r;
    endfunction

endpackage

### rtl/core/pbd_particle_chain_step.sv
// ----------------------------------------------------------------------------
// pbd_particle_chain_step
// Position based dynamics chain: particle store, integration and distance
// constraint relaxation, reporting every particle position after a step.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) takes one request at a time; opcode
//   load writes one particle in the cycle it is accepted, opcode step runs a whole step
//   output channel (out_valid / out_stall) returns one position per particle
//   in use, slot 0 first, last set on the final one; a step with count zero
//   returns nothing; registers are to be written over the APB port only
//   while the block is idle, which the block itself leaves unchecked
// step sequence, n particles in use, P relaxation passes:
//   integration of every particle (a pinned one is written back unchanged),
//   then P passes over the n-1 neighbouring pairs, then one report per
//   particle; pairs use the bit-serial square root and bit-serial divider
//   (one division per axis), and a single multiplier serves the whole step
// positions and velocities live in two single-port-write memories with a
//   registered read; each pair is written back before the next one is read
// reset clears the registers to their defaults and the control state; the
//   particle memories hold nothing until loaded
// a stalled output holds its request; the sequencer waits on it and the input
//   stays stalled until the last position has been registered
// ----------------------------------------------------------------------------
`include "pbd_particle_chain_step_assert.svh"

module pbd_particle_chain_step #(
    parameter int MAX_PARTICLES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [pbd_pkg::DATA_W-1:0]  pwdata,
    output logic [pbd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [pbd_pkg::SLOT_W-1:0]  slot,
    input  pbd_pkg::q_t                 load_px,
    input  pbd_pkg::q_t                 load_py,
    input  pbd_pkg::q_t                 load_pz,
    input  pbd_pkg::q_t                 load_vx,
    input  pbd_pkg::q_t                 load_vy,
    input  pbd_pkg::q_t                 load_vz,
    input  logic                        pinned,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pbd_pkg::SLOT_W-1:0]  out_slot,
    output pbd_pkg::q_t                 out_px,
    output pbd_pkg::q_t                 out_py,
    output pbd_pkg::q_t                 out_pz,
    output logic                        last
);

    import pbd_pkg::*;

    localparam int IW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);
    localparam logic signed [WIDE_W-1:0] RND_HALF = WIDE_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [5:0] SQRT_END = 6'd31;
    localparam logic [5:0] DIV_END  = 6'd63;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_I_RD    = 5'd1;
    localparam logic [4:0] ST_I_LD    = 5'd2;
    localparam logic [4:0] ST_I_MUL   = 5'd3;
    localparam logic [4:0] ST_I_APPLY = 5'd4;
    localparam logic [4:0] ST_I_WR    = 5'd5;
    localparam logic [4:0] ST_P_RDA   = 5'd6;
    localparam logic [4:0] ST_P_RDB   = 5'd7;
    localparam logic [4:0] ST_P_LDB   = 5'd8;
    localparam logic [4:0] ST_P_SQM   = 5'd9;
    localparam logic [4:0] ST_P_SQA   = 5'd10;
    localparam logic [4:0] ST_P_SQRT  = 5'd11;
    localparam logic [4:0] ST_P_OVER  = 5'd12;
    localparam logic [4:0] ST_P_CMUL  = 5'd13;
    localparam logic [4:0] ST_P_CDIV  = 5'd14;
    localparam logic [4:0] ST_P_DIV   = 5'd15;
    localparam logic [4:0] ST_P_CFIN  = 5'd16;
    localparam logic [4:0] ST_P_WA    = 5'd17;
    localparam logic [4:0] ST_P_WB    = 5'd18;
    localparam logic [4:0] ST_O_RD    = 5'd19;
    localparam logic [4:0] ST_O_LD    = 5'd20;

    // configuration
    logic [CNT_W-1:0]         particle_count_reg;
    logic [TS_W-1:0]          time_step_reg;
    logic signed [GRAV_W-1:0] gravity_y_reg;
    logic [DAMP_W-1:0]        damping_reg;
    logic [REST_W-1:0]        rest_length_reg;
    logic [PASS_W-1:0]        pass_count_reg;

    // memories
    logic [95:0] pos_mem [MAX_PARTICLES];
    logic [96:0] vel_mem [MAX_PARTICLES];
    logic [95:0] pos_rd_reg;
    logic [96:0] vel_rd_reg;
    logic        pos_we;
    logic        vel_we;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;
    logic [95:0] pos_wdata;
    logic [96:0] vel_wdata;

    // sequencer
    logic [4:0]        state_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     pair_reg;
    logic [CW-1:0]     oi_reg;
    logic [PASS_W-1:0] pass_reg;
    logic [1:0]        ax_reg;
    logic              phase_reg;
    logic [5:0]        cnt_reg;

    // datapath
    q_t                        p_reg  [3];
    q_t                        v_reg  [3];
    q_t                        pb_reg [3];
    q_t                        d_reg  [3];
    logic signed [33:0]        c_reg  [3];
    logic                      pin_a_reg;
    logic                      pin_b_reg;
    logic signed [WIDE_W-1:0]  prod_reg;
    logic [63:0]               sq_reg;
    logic [35:0]               srem_reg;
    logic [31:0]               root_reg;
    logic signed [33:0]        over_reg;
    logic [63:0]               num_reg;
    logic [32:0]               drem_reg;
    logic [32:0]               den_reg;

    // output register
    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    q_t                out_px_reg;
    q_t                out_py_reg;
    q_t                out_pz_reg;
    logic              last_reg;

    logic              cfg_wr;
    logic              in_accept;
    logic [CW-1:0]     n_eff;
    logic              pass_go;
    logic              idx_last;
    logic [CW-1:0]     pair_nx;
    logic              pair_last;
    logic              pass_last;
    logic              out_load;
    logic              oi_last;
    logic signed [33:0]        mul_a;
    logic signed [33:0]        mul_b;
    logic signed [WIDE_W-1:0]  rnd;
    logic [31:0]               md;
    logic [32:0]               mo;
    logic [33:0]               mo_full;
    logic [35:0]               srem_sh;
    logic [35:0]               strial;
    logic                      sfit;
    logic [33:0]               dsh;
    logic                      dfit;
    logic [32:0]               q_mag;
    logic                      c_neg;

    // ---------------------------------------------------------------- config
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_count_reg <= CNT_W'(5);
            time_step_reg      <= TS_W'(66);
            gravity_y_reg      <= -18'sd643;
            damping_reg        <= DAMP_W'(64881);
            rest_length_reg    <= REST_W'(6554);
            pass_count_reg     <= PASS_W'(3);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_COUNT: particle_count_reg <= pwdata[CNT_W-1:0];
                REG_TSTEP: time_step_reg      <= pwdata[TS_W-1:0];
                REG_GRAV:  gravity_y_reg      <= signed'(pwdata[GRAV_W-1:0]);
                REG_DAMP:  damping_reg        <= pwdata[DAMP_W-1:0];
                REG_REST:  rest_length_reg    <= pwdata[REST_W-1:0];
                REG_PASS:  pass_count_reg     <= pwdata[PASS_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_COUNT: prdata = DATA_W'(particle_count_reg);
            REG_TSTEP: prdata = DATA_W'(time_step_reg);
            REG_GRAV:  prdata = DATA_W'(gravity_y_reg);
            REG_DAMP:  prdata = DATA_W'(damping_reg);
            REG_REST:  prdata = DATA_W'(rest_length_reg);
            REG_PASS:  prdata = DATA_W'(pass_count_reg);
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- control terms
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign n_eff = (32'(particle_count_reg) > MAX_PARTICLES) ? CW'(MAX_PARTICLES)
                                                            : CW'(particle_count_reg);
    assign pass_go   = (pass_count_reg != '0) && (n_eff >= TWO_C);
    assign idx_last  = (CW'(idx_reg + ONE_C) == n_eff);
    assign pair_nx   = CW'(pair_reg + ONE_C);
    assign pair_last = (CW'(pair_reg + TWO_C) == n_eff);
    assign pass_last = (PASS_W'(pass_reg + PASS_W'(1)) == pass_count_reg);
    assign oi_last   = (CW'(oi_reg + ONE_C) == n_eff);
    assign out_load  = (state_reg == ST_O_LD) && (!out_valid_reg || !out_stall);

    // ---------------------------------------------------------------- arithmetic
    assign mo_full = over_reg[33] ? 34'(~over_reg + 34'sd1) : 34'(over_reg);
    assign mo      = mo_full[32:0];
    assign md      = d_reg[ax_reg][31] ? (32'(~d_reg[ax_reg]) + 32'd1) : 32'(d_reg[ax_reg]);

    always_comb
    begin
        case (state_reg)
            ST_I_MUL:
            begin
                mul_a = 34'(v_reg[ax_reg]);
                mul_b = phase_reg ? signed'(34'(time_step_reg)) : signed'(34'(damping_reg));
            end
            ST_P_SQM:
            begin
                mul_a = 34'(d_reg[ax_reg]);
                mul_b = 34'(d_reg[ax_reg]);
            end
            default:
            begin
                mul_a = signed'({2'b00, md});
                mul_b = signed'({1'b0, mo});
            end
        endcase
    end

    assign rnd = (prod_reg + RND_HALF) >>> FRAC_BITS;

    // one root bit per cycle
    assign srem_sh = {srem_reg[33:0], sq_reg[63:62]};
    assign strial  = {2'b00, root_reg, 2'b01};
    assign sfit    = (srem_sh >= strial);

    // one quotient bit per cycle
    assign dsh  = {drem_reg, num_reg[63]};
    assign dfit = (dsh >= {1'b0, den_reg});

    assign q_mag = num_reg[32:0];
    assign c_neg = d_reg[ax_reg][31] ^ over_reg[33];

    // ---------------------------------------------------------------- memory ports
    always_comb
    begin
        pos_we    = 1'b0;
        vel_we    = 1'b0;
        waddr     = idx_reg[IW-1:0];
        pos_wdata = {p_reg[2], p_reg[1], p_reg[0]};
        vel_wdata = {pin_a_reg, v_reg[2], v_reg[1], v_reg[0]};
        case (state_reg)
            ST_IDLE:
            begin
                waddr     = IW'(slot);
                pos_wdata = {load_pz, load_py, load_px};
                vel_wdata = {pinned, load_vz, load_vy, load_vx};
                if (in_accept && (opcode == OP_LOAD) && (32'(slot) < MAX_PARTICLES))
                begin
                    pos_we = 1'b1;
                    vel_we = 1'b1;
                end
            end
            ST_I_WR:
            begin
                pos_we = 1'b1;
                vel_we = 1'b1;
            end
            ST_P_WA:
            begin
                pos_we    = !pin_a_reg;
                waddr     = pair_reg[IW-1:0];
                pos_wdata = {sat32(WIDE_W'(p_reg[2]) + WIDE_W'(c_reg[2])),
                             sat32(WIDE_W'(p_reg[1]) + WIDE_W'(c_reg[1])),
                             sat32(WIDE_W'(p_reg[0]) + WIDE_W'(c_reg[0]))};
            end
            ST_P_WB:
            begin
                pos_we    = !pin_b_reg;
                waddr     = pair_nx[IW-1:0];
                pos_wdata = {sat32(WIDE_W'(pb_reg[2]) - WIDE_W'(c_reg[2])),
                             sat32(WIDE_W'(pb_reg[1]) - WIDE_W'(c_reg[1])),
                             sat32(WIDE_W'(pb_reg[0]) - WIDE_W'(c_reg[0]))};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        case (state_reg) inside
            ST_P_RDA:         raddr = pair_reg[IW-1:0];
            ST_P_RDB:         raddr = pair_nx[IW-1:0];
            ST_O_RD, ST_O_LD: raddr = oi_reg[IW-1:0];
            default:          raddr = idx_reg[IW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[waddr] <= pos_wdata;
        end
        if (vel_we)
        begin
            vel_mem[waddr] <= vel_wdata;
        end
        pos_rd_reg <= pos_mem[raddr];
        vel_rd_reg <= vel_mem[raddr];
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pair_reg      <= '0;
            pass_reg      <= '0;
            oi_reg        <= '0;
            ax_reg        <= '0;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (opcode == OP_STEP) && (n_eff != '0))
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_I_RD;
                    end
                end
                ST_I_RD:
                begin
                    state_reg <= ST_I_LD;
                end
                ST_I_LD:
                begin
                    p_reg[0]  <= q_t'(pos_rd_reg[31:0]);
                    p_reg[1]  <= q_t'(pos_rd_reg[63:32]);
                    p_reg[2]  <= q_t'(pos_rd_reg[95:64]);
                    v_reg[0]  <= q_t'(vel_rd_reg[31:0]);
                    v_reg[2]  <= q_t'(vel_rd_reg[95:64]);
                    pin_a_reg <= vel_rd_reg[96];
                    ax_reg    <= '0;
                    phase_reg <= 1'b0;
                    if (vel_rd_reg[96])
                    begin
                        // pinned: write back unchanged
                        v_reg[1]  <= q_t'(vel_rd_reg[63:32]);
                        state_reg <= ST_I_WR;
                    end
                    else
                    begin
                        v_reg[1]  <= sat32(WIDE_W'(q_t'(vel_rd_reg[63:32]))
                                           + WIDE_W'(gravity_y_reg));
                        state_reg <= ST_I_MUL;
                    end
                end
                ST_I_MUL:
                begin
                    prod_reg  <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
                    state_reg <= ST_I_APPLY;
                end
                ST_I_APPLY:
                begin
                    if (!phase_reg)
                    begin
                        v_reg[ax_reg] <= sat32(rnd);
                        phase_reg     <= 1'b1;
                        state_reg     <= ST_I_MUL;
                    end
                    else
                    begin
                        p_reg[ax_reg] <= sat32(WIDE_W'(p_reg[ax_reg]) + rnd);
                        phase_reg     <= 1'b0;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= ST_I_WR;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= ST_I_MUL;
                        end
                    end
                end
                ST_I_WR:
                begin
                    idx_reg <= CW'(idx_reg + ONE_C);
                    if (idx_last)
                    begin
                        pair_reg  <= '0;
                        pass_reg  <= '0;
                        oi_reg    <= '0;
                        state_reg <= pass_go ? ST_P_RDA : ST_O_RD;
                    end
                    else
                    begin
                        state_reg <= ST_I_RD;
                    end
                end
                ST_P_RDA:
                begin
                    state_reg <= ST_P_RDB;
                end
                ST_P_RDB:
                begin
                    p_reg[0]  <= q_t'(pos_rd_reg[31:0]);
                    p_reg[1]  <= q_t'(pos_rd_reg[63:32]);
                    p_reg[2]  <= q_t'(pos_rd_reg[95:64]);
                    pin_a_reg <= vel_rd_reg[96];
                    state_reg <= ST_P_LDB;
                end
                ST_P_LDB:
                begin
                    pb_reg[0] <= q_t'(pos_rd_reg[31:0]);
                    pb_reg[1] <= q_t'(pos_rd_reg[63:32]);
                    pb_reg[2] <= q_t'(pos_rd_reg[95:64]);
                    d_reg[0]  <= sat32(WIDE_W'(q_t'(pos_rd_reg[31:0])) - WIDE_W'(p_reg[0]));
                    d_reg[1]  <= sat32(WIDE_W'(q_t'(pos_rd_reg[63:32])) - WIDE_W'(p_reg[1]));
                    d_reg[2]  <= sat32(WIDE_W'(q_t'(pos_rd_reg[95:64])) - WIDE_W'(p_reg[2]));
                    pin_b_reg <= vel_rd_reg[96];
                    sq_reg    <= '0;
                    ax_reg    <= '0;
                    state_reg <= ST_P_SQM;
                end
                ST_P_SQM:
                begin
                    prod_reg  <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
                    state_reg <= ST_P_SQA;
                end
                ST_P_SQA:
                begin
                    sq_reg <= sq_reg + prod_reg[63:0];
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        cnt_reg   <= '0;
                        root_reg  <= '0;
                        srem_reg  <= '0;
                        state_reg <= ST_P_SQRT;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_P_SQM;
                    end
                end
                ST_P_SQRT:
                begin
                    srem_reg <= sfit ? (srem_sh - strial) : srem_sh;
                    root_reg <= {root_reg[30:0], sfit};
                    sq_reg   <= {sq_reg[61:0], 2'b00};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == SQRT_END)
                    begin
                        state_reg <= ST_P_OVER;
                    end
                end
                ST_P_OVER:
                begin
                    if (root_reg == '0)
                    begin
                        // coincident pair: leave both particles alone
                        if (pair_last)
                        begin
                            pair_reg <= '0;
                            pass_reg <= PASS_W'(pass_reg + PASS_W'(1));
                            state_reg <= pass_last ? ST_O_RD : ST_P_RDA;
                        end
                        else
                        begin
                            pair_reg  <= pair_nx;
                            state_reg <= ST_P_RDA;
                        end
                    end
                    else
                    begin
                        over_reg  <= signed'(34'(root_reg)) - signed'(34'(rest_length_reg));
                        ax_reg    <= '0;
                        state_reg <= ST_P_CMUL;
                    end
                end
                ST_P_CMUL:
                begin
                    prod_reg  <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
                    state_reg <= ST_P_CDIV;
                end
                ST_P_CDIV:
                begin
                    num_reg   <= prod_reg[63:0] + 64'(root_reg);
                    den_reg   <= {root_reg, 1'b0};
                    drem_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_P_DIV;
                end
                ST_P_DIV:
                begin
                    drem_reg <= dfit ? 33'(dsh - {1'b0, den_reg}) : dsh[32:0];
                    num_reg  <= {num_reg[62:0], dfit};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_END)
                    begin
                        state_reg <= ST_P_CFIN;
                    end
                end
                ST_P_CFIN:
                begin
                    c_reg[ax_reg] <= c_neg ? -signed'({1'b0, q_mag}) : signed'({1'b0, q_mag});
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= ST_P_WA;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_P_CMUL;
                    end
                end
                ST_P_WA:
                begin
                    state_reg <= ST_P_WB;
                end
                ST_P_WB:
                begin
                    if (pair_last)
                    begin
                        pair_reg <= '0;
                        pass_reg <= PASS_W'(pass_reg + PASS_W'(1));
                        state_reg <= pass_last ? ST_O_RD : ST_P_RDA;
                    end
                    else
                    begin
                        pair_reg  <= pair_nx;
                        state_reg <= ST_P_RDA;
                    end
                end
                ST_O_RD:
                begin
                    state_reg <= ST_O_LD;
                end
                ST_O_LD:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_slot_reg  <= SLOT_W'(oi_reg);
                        out_px_reg    <= q_t'(pos_rd_reg[31:0]);
                        out_py_reg    <= q_t'(pos_rd_reg[63:32]);
                        out_pz_reg    <= q_t'(pos_rd_reg[95:64]);
                        last_reg      <= oi_last;
                        oi_reg        <= CW'(oi_reg + ONE_C);
                        state_reg     <= oi_last ? ST_IDLE : ST_O_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign out_px    = out_px_reg;
    assign out_py    = out_py_reg;
    assign out_pz    = out_pz_reg;
    assign last      = last_reg;

    // ---------------------------------------------------------------- assertions
    `PBD_ASSERT_IMPLY(a_div_den_nonzero, state_reg == ST_P_DIV, den_reg != '0)
    `PBD_ASSERT_IMPLY(a_out_in_range, state_reg == ST_O_LD, oi_reg < n_eff)
    `PBD_ASSERT_IMPLY(a_pair_in_range, state_reg == ST_P_RDA, pair_nx < n_eff)
    `PBD_ASSERT_NEXT(a_load_one_cycle, in_accept && (opcode == OP_LOAD), state_reg == ST_IDLE)

endmodule
